@@ rtl/core/bipd_pkg.sv @@
// ----------------------------------------------------------------------------
// bipd_pkg
// Shared types, opcode length table and flow codes for the predecoder.
// ----------------------------------------------------------------------------
package bipd_pkg;

    localparam logic [1:0] L1 = 2'd1;
    localparam logic [1:0] L2 = 2'd2;
    localparam logic [1:0] L3 = 2'd3;

    localparam logic [1:0] OP_LEN [256] = '{
        L1, L2, L3, L1, L1, L2, L1, L1, L1, L1, L1, L1, L1, L1, L1, L1,
        L3, L2, L3, L1, L1, L2, L1, L1, L1, L1, L1, L1, L1, L1, L1, L1,
        L3, L2, L1, L1, L2, L2, L1, L1, L1, L1, L1, L1, L1, L1, L1, L1,
        L3, L2, L1, L1, L2, L2, L1, L1, L1, L1, L1, L1, L1, L1, L1, L1,
        L2, L2, L2, L3, L2, L2, L1, L1, L1, L1, L1, L1, L1, L1, L1, L1,
        L2, L2, L2, L3, L2, L2, L1, L1, L1, L1, L1, L1, L1, L1, L1, L1,
        L2, L2, L2, L3, L2, L2, L1, L1, L1, L1, L1, L1, L1, L1, L1, L1,
        L2, L2, L2, L1, L2, L3, L2, L2, L2, L2, L2, L2, L2, L2, L2, L2,
        L2, L2, L2, L1, L1, L3, L2, L2, L2, L2, L2, L2, L2, L2, L2, L2,
        L3, L2, L2, L1, L2, L2, L1, L1, L1, L1, L1, L1, L1, L1, L1, L1,
        L2, L2, L2, L1, L1, L1, L2, L2, L2, L2, L2, L2, L2, L2, L2, L2,
        L2, L2, L2, L1, L3, L3, L3, L3, L3, L3, L3, L3, L3, L3, L3, L3,
        L2, L2, L2, L1, L1, L2, L1, L1, L1, L1, L1, L1, L1, L1, L1, L1,
        L2, L2, L2, L1, L1, L3, L1, L1, L2, L2, L2, L2, L2, L2, L2, L2,
        L1, L2, L1, L1, L1, L2, L1, L1, L1, L1, L1, L1, L1, L1, L1, L1,
        L1, L2, L1, L1, L1, L2, L1, L1, L1, L1, L1, L1, L1, L1, L1, L1
    };

    localparam logic [7:0] UNDEF_OPCODE = 8'ha5;
    localparam logic [15:0] PAGE_MASK   = 16'hf800;

    localparam logic [7:0] OPC_NOP        = 8'h00;
    localparam logic [7:0] OPC_AJMP       = 8'h01;
    localparam logic [7:0] OPC_LJMP       = 8'h02;
    localparam logic [7:0] OPC_JBC        = 8'h10;
    localparam logic [7:0] OPC_ACALL      = 8'h11;
    localparam logic [7:0] OPC_LCALL      = 8'h12;
    localparam logic [7:0] OPC_RET        = 8'h22;
    localparam logic [7:0] OPC_RETI       = 8'h32;
    localparam logic [7:0] OPC_JNZ        = 8'h70;
    localparam logic [7:0] OPC_JMP_IND    = 8'h73;
    localparam logic [7:0] OPC_SJMP       = 8'h80;
    localparam logic [7:0] OPC_MOV_DPTR   = 8'h90;
    localparam logic [7:0] OPC_CJNE_FIRST = 8'hb4;
    localparam logic [7:0] OPC_CJNE_LAST  = 8'hbf;
    localparam logic [7:0] OPC_DJNZ_DIR   = 8'hd5;
    localparam logic [7:0] OPC_DJNZ_R0    = 8'hd8;
    localparam logic [7:0] OPC_DJNZ_R7    = 8'hdf;

    localparam logic [2:0] FLOW_UNDEF  = 3'd0;
    localparam logic [2:0] FLOW_PLAIN  = 3'd1;
    localparam logic [2:0] FLOW_JUMP   = 3'd2;
    localparam logic [2:0] FLOW_BRANCH = 3'd3;
    localparam logic [2:0] FLOW_RETURN = 3'd4;

    typedef enum logic [1:0] {
        TGT_NONE,
        TGT_ABS,
        TGT_REL,
        TGT_PAGE
    } t_target_form;

    typedef struct packed {
        logic [15:0] address;
        logic [7:0]  opcode;
        logic [7:0]  operand1;
        logic [7:0]  operand2;
    } t_instr;

    typedef struct packed {
        logic [15:0] address;
        logic [7:0]  opcode;
        logic [7:0]  operand1;
        logic [7:0]  operand2;
        logic [1:0]  length;
        logic [2:0]  flow;
        logic        has_target;
        logic [15:0] target;
    } t_result;

    typedef struct packed {
        logic restart;
        logic accept;
        logic advance;
    } t_gather_ctl;

endpackage

@@ rtl/core/bipd_gather.sv @@
// ----------------------------------------------------------------------------
// bipd_gather
// Collects code bytes into whole instructions and holds a finished one in
// the instruction register.
// ----------------------------------------------------------------------------
module bipd_gather import bipd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_gather_ctl i_ctl,
    input  logic [15:0] i_start_address,
    input  logic [7:0]  i_code_byte,
    output logic        o_instr_valid,
    output t_instr      o_instr
);

    logic [15:0] r_fetch, n_fetch;
    logic [15:0] r_instr_start, n_instr_start;
    logic [1:0]  r_held, n_held;
    logic [7:0]  r_opcode, n_opcode;
    logic [7:0]  r_operand, n_operand;
    logic        r_valid, n_valid;
    t_instr      r_instr, n_instr;

    always_comb begin
        logic   done;
        t_instr rec;
        done          = 1'b0;
        rec           = '0;
        n_fetch       = r_fetch;
        n_instr_start = r_instr_start;
        n_held        = r_held;
        n_opcode      = r_opcode;
        n_operand     = r_operand;
        if (i_ctl.restart) begin
            n_fetch       = i_start_address;
            n_instr_start = i_start_address;
            n_held        = 2'd0;
        end else if (i_ctl.accept) begin
            n_fetch = r_fetch + 16'd1;
            case (r_held)
                2'd0: begin
                    n_instr_start = r_fetch;
                    n_opcode      = i_code_byte;
                    if (OP_LEN[i_code_byte] == L1) begin
                        done   = 1'b1;
                        rec    = '{address: r_fetch, opcode: i_code_byte,
                                   operand1: 8'd0, operand2: 8'd0};
                        n_held = 2'd0;
                    end else begin
                        n_held = 2'd1;
                    end
                end
                2'd1: begin
                    if (OP_LEN[r_opcode] == L3) begin
                        n_operand = i_code_byte;
                        n_held    = 2'd2;
                    end else begin
                        done   = 1'b1;
                        rec    = '{address: r_instr_start, opcode: r_opcode,
                                   operand1: i_code_byte, operand2: 8'd0};
                        n_held = 2'd0;
                    end
                end
                2'd2: begin
                    done   = 1'b1;
                    rec    = '{address: r_instr_start, opcode: r_opcode,
                               operand1: r_operand, operand2: i_code_byte};
                    n_held = 2'd0;
                end
                default: begin
                    n_held = 2'd0;
                end
            endcase
        end
        n_instr = r_instr;
        n_valid = r_valid;
        if (done) begin
            n_instr = rec;
            n_valid = 1'b1;
        end else if (i_ctl.advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fetch       <= 16'd0;
            r_instr_start <= 16'd0;
            r_held        <= 2'd0;
            r_opcode      <= 8'd0;
            r_operand     <= 8'd0;
            r_valid       <= 1'b0;
        end else begin
            r_fetch       <= n_fetch;
            r_instr_start <= n_instr_start;
            r_held        <= n_held;
            r_opcode      <= n_opcode;
            r_operand     <= n_operand;
            r_valid       <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_instr <= n_instr;
    end

    assign o_instr_valid = r_valid;
    assign o_instr       = r_instr;

    // only three-byte opcodes ever park a second byte
    a_held_two_is_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held == 2'd2) |-> (OP_LEN[r_opcode] == L3))
        else $error("two bytes held for a short opcode");

    a_held_never_three: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held != 2'd3)
        else $error("byte count out of range");

    a_done_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.accept && !i_ctl.restart && r_held == 2'd2) |=> (r_held == 2'd0 && r_valid))
        else $error("three-byte instruction did not complete");

endmodule

@@ rtl/core/bipd_decode.sv @@
// ----------------------------------------------------------------------------
// bipd_decode
// Length, control-flow kind and branch target of one gathered instruction.
// ----------------------------------------------------------------------------
module bipd_decode import bipd_pkg::*; (
    input  t_instr  i_instr,
    output t_result o_result
);

    function automatic logic [2:0] flow_of(input logic [7:0] op);
        logic [2:0] f;
        f = FLOW_PLAIN;
        if (op == UNDEF_OPCODE) begin
            f = FLOW_UNDEF;
        end else if (op == OPC_RET || op == OPC_RETI) begin
            f = FLOW_RETURN;
        end else if (op[4:0] == OPC_AJMP[4:0] || op == OPC_LJMP ||
                     op == OPC_JMP_IND || op == OPC_SJMP) begin
            f = FLOW_JUMP;
        end else if (op[4:0] == OPC_ACALL[4:0] || op == OPC_LCALL) begin
            f = FLOW_BRANCH;
        end else if (op[3:0] == OPC_JBC[3:0] && op >= OPC_JBC && op <= OPC_JNZ) begin
            f = FLOW_BRANCH;
        end else if (op >= OPC_CJNE_FIRST && op <= OPC_CJNE_LAST) begin
            f = FLOW_BRANCH;
        end else if (op == OPC_DJNZ_DIR || (op >= OPC_DJNZ_R0 && op <= OPC_DJNZ_R7)) begin
            f = FLOW_BRANCH;
        end
        return f;
    endfunction

    function automatic t_target_form form_of(input logic [7:0] op);
        t_target_form t;
        t = TGT_NONE;
        if (op[3:0] == OPC_AJMP[3:0]) begin
            t = TGT_PAGE;
        end else if (op == OPC_LJMP || op == OPC_LCALL) begin
            t = TGT_ABS;
        end else if (op[3:0] == OPC_JBC[3:0] && op >= OPC_JBC && op <= OPC_SJMP) begin
            t = TGT_REL;
        end else if (op >= OPC_CJNE_FIRST && op <= OPC_CJNE_LAST) begin
            t = TGT_REL;
        end else if (op == OPC_DJNZ_DIR || (op >= OPC_DJNZ_R0 && op <= OPC_DJNZ_R7)) begin
            t = TGT_REL;
        end
        return t;
    endfunction

    logic [1:0]   len;
    logic [15:0]  next_addr;
    logic [7:0]   last_byte;
    t_target_form form;

    always_comb begin
        len       = OP_LEN[i_instr.opcode];
        next_addr = i_instr.address + {14'd0, len};
        case (len)
            L2:      last_byte = i_instr.operand1;
            L3:      last_byte = i_instr.operand2;
            default: last_byte = i_instr.opcode;
        endcase
        form = form_of(i_instr.opcode);

        o_result.address    = i_instr.address;
        o_result.opcode     = i_instr.opcode;
        o_result.operand1   = i_instr.operand1;
        o_result.operand2   = i_instr.operand2;
        o_result.length     = len;
        o_result.flow       = flow_of(i_instr.opcode);
        o_result.has_target = (form != TGT_NONE);
        case (form)
            TGT_ABS:  o_result.target = {i_instr.operand1, i_instr.operand2};
            TGT_REL:  o_result.target = next_addr + {{8{last_byte[7]}}, last_byte};
            TGT_PAGE: o_result.target = {next_addr[15:11], i_instr.opcode[7:5], last_byte};
            default:  o_result.target = 16'd0;
        endcase
    end

endmodule

@@ rtl/core/bipd_out_buf.sv @@
// ----------------------------------------------------------------------------
// bipd_out_buf
// Two-entry result buffer; keeps the gatherer moving while the sink stalls.
// ----------------------------------------------------------------------------
module bipd_out_buf import bipd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_data
);

    t_result     r_buf [2];
    logic        r_wr_ptr, n_wr_ptr;
    logic        r_rd_ptr, n_rd_ptr;
    logic [1:0]  r_count, n_count;
    logic        pop;

    assign pop     = (r_count != 2'd0) && !i_stall;
    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_data  = r_buf[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = pop ? ~r_rd_ptr : r_rd_ptr;
        case ({i_push, pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_data;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("result count out of range");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != 2'd2))
        else $error("push into full buffer");

    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd0 || r_count == 2'd2) |-> (r_wr_ptr == r_rd_ptr))
        else $error("pointers disagree with count");

endmodule

@@ rtl/core/byte_isa_instruction_predecoder_unit.sv @@
// ----------------------------------------------------------------------------
// byte_isa_instruction_predecoder_unit
// Predecodes a stream of 8-bit controller code bytes into instructions with
// length, control-flow kind and branch target.
//
//   channel  direction  handshake                 payload
//   in       sink       i_in_valid / o_in_stall   i_code_byte
//   out      source     o_out_valid / i_out_stall instruction fields
//   cfg      APB slave  psel/penable/pwrite       start_address at 0x0
//
// One code byte per cycle is taken while o_in_stall is low; an instruction's result
// is registered in the instruction register and then in a two-entry result
// buffer before it appears on the out channel.
// o_in_stall rises only when a finished instruction waits and the buffer is
// full. Synchronous reset clears the stream to address 0, no items pending.
// Writing start_address restarts the stream and drops partial instructions.
// ----------------------------------------------------------------------------
module byte_isa_instruction_predecoder_unit import bipd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_code_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_instr_address,
    output logic [7:0]  o_opcode_value,
    output logic [7:0]  o_first_operand,
    output logic [7:0]  o_second_operand,
    output logic [1:0]  o_instr_length,
    output logic [2:0]  o_flow_kind,
    output logic        o_has_target,
    output logic [15:0] o_branch_target
);

    logic [15:0] r_start_address;
    logic        cfg_write;
    logic        instr_valid;
    logic        buf_full;
    t_instr      instr;
    t_result     dec_result;
    t_result     out_result;
    t_gather_ctl ctl;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata    = (paddr[2] == 1'b0) ? {16'd0, r_start_address} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_address <= 16'd0;
        end else if (cfg_write) begin
            r_start_address <= pwdata[15:0];
        end
    end

    assign o_in_stall  = instr_valid && buf_full;
    assign ctl.restart = cfg_write;
    assign ctl.accept  = i_in_valid && !o_in_stall;
    assign ctl.advance = instr_valid && !buf_full;

    bipd_gather u_gather (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (ctl),
        .i_start_address (pwdata[15:0]),
        .i_code_byte     (i_code_byte),
        .o_instr_valid   (instr_valid),
        .o_instr         (instr)
    );

    bipd_decode u_decode (
        .i_instr  (instr),
        .o_result (dec_result)
    );

    bipd_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (ctl.advance),
        .i_data  (dec_result),
        .o_full  (buf_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (out_result)
    );

    assign o_instr_address  = out_result.address;
    assign o_opcode_value   = out_result.opcode;
    assign o_first_operand  = out_result.operand1;
    assign o_second_operand = out_result.operand2;
    assign o_instr_length   = out_result.length;
    assign o_flow_kind      = out_result.flow;
    assign o_has_target     = out_result.has_target;
    assign o_branch_target  = out_result.target;

endmodule
